// ===== hdl/fhd_pkg.sv =====
`default_nettype none
package fhd_pkg;

  // opcodes carried in tuser
  localparam logic [2:0] OP_IOT60 = 3'd0;
  localparam logic [2:0] OP_IOT61 = 3'd1;
  localparam logic [2:0] OP_IOT62 = 3'd2;
  localparam logic [2:0] OP_XFER  = 3'd3;
  localparam logic [2:0] OP_RESET = 3'd4;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_NEXT  = 2'd2;

  localparam logic [1:0] MV_NONE  = 2'd0;
  localparam logic [1:0] MV_READ  = 2'd1;
  localparam logic [1:0] MV_WRITE = 2'd2;

  localparam logic [2:0] FN_READ = 3'd2;

  // status bits
  localparam logic [11:0] ST_PCELL = 12'o4000;
  localparam logic [11:0] ST_DEX   = 12'o3700;
  localparam logic [11:0] ST_MEX   = 12'o0070;
  localparam logic [11:0] ST_NXD   = 12'o0002;
  localparam logic [11:0] ST_WLS   = 12'o0002;
  localparam logic [11:0] ST_ERR   = 12'o0007;

  localparam logic [11:0] PCELL_WINDOW = 12'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_WRITE_LOCK    = 2'd0;
  localparam logic [1:0] CFG_PLATTERS      = 2'd1;
  localparam logic [1:0] CFG_MEMORY_FIELDS = 2'd2;
  localparam logic [1:0] CFG_BURST         = 2'd3;

  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic [7:0] write_lock;
    logic [2:0] platters;
    logic [3:0] memory_fields;
    logic       burst;
  } cfg_t;

  typedef struct packed {
    logic [11:0] memory_address;
    logic [11:0] word_count;
    logic [10:0] position;
    logic [11:0] ac;
    logic [2:0]  pulse;
    logic [2:0]  opcode;
  } in_item_t;

  typedef struct packed {
    logic [11:0] status_out;
    logic        interrupt;
    logic        done_out;
    logic [1:0]  move;
    logic [16:0] disk_word_address;
    logic [14:0] physical_address;
    logic [11:0] address_out;
    logic [11:0] count_out;
    logic [10:0] delay_words;
    logic [1:0]  next_event;
    logic        skip;
    logic [11:0] ac_out;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/fixed_head_disk_controller.sv =====
// Head-per-track disk controller: decodes device IOT pulses (groups 60, 61, 62),
// steps one data-break word per transfer transaction and handles controller
// reset, returning one result per input transaction. An input transaction is
// held in an input register, decoded against the controller state in one
// combinational pass, and the result lands in an output register; the state
// updates as the item moves into that register. One transaction is taken every
// clock while the output side keeps up. The result passes through the input
// register and then the result register before it is valid at the output. The
// user must write the configuration registers only while no transaction is in
// flight; the block itself does not enforce this.
`default_nettype none
module fixed_head_disk_controller #(
  parameter int WORDS_PER_TRACK = 2048,
  parameter int PLATTER_WORDS   = 32768
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // pulse, ac, position, word_count, memory_address, zero pad
  input  wire logic [fhd_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  wire logic [2:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // ac_out, skip, next_event, delay_words, count_out, address_out,
  // physical_address, disk_word_address, move, done_out, interrupt, status_out, zero pad
  output logic [fhd_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [fhd_pkg::CFG_DATA_W-1:0] cfg_data
);

  fhd_pkg::in_item_t in_item;
  fhd_pkg::in_item_t cur_item;
  fhd_pkg::res_t     res;
  fhd_pkg::res_t     out_res;
  fhd_pkg::cfg_t     cfg;
  logic              cur_valid;
  logic              out_ready;

  assign in_item.opcode         = s_tuser;
  assign in_item.pulse          = s_tdata[2:0];
  assign in_item.ac             = s_tdata[14:3];
  assign in_item.position       = s_tdata[25:15];
  assign in_item.word_count     = s_tdata[37:26];
  assign in_item.memory_address = s_tdata[49:38];

  fhd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fhd_stage #(
    .WIDTH ($bits(fhd_pkg::in_item_t))
  ) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_item),
    .out_valid (cur_valid),
    .out_ready (out_ready),
    .out_data  (cur_item)
  );

  fhd_core #(
    .WORDS_PER_TRACK (WORDS_PER_TRACK),
    .PLATTER_WORDS   (PLATTER_WORDS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .item (cur_item),
    .fire (cur_valid && out_ready),
    .cfg  (cfg),
    .res  (res)
  );

  fhd_stage #(
    .WIDTH ($bits(fhd_pkg::res_t))
  ) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cur_valid),
    .in_ready  (out_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {6'd0, out_res};

endmodule
`default_nettype wire

// ===== hdl/fhd_stage.sv =====
`default_nettype none
module fhd_stage #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic             valid;
  logic [WIDTH-1:0] data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fhd_cfg.sv =====
`default_nettype none
module fhd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [fhd_pkg::CFG_DATA_W-1:0] cfg_data,
  output fhd_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_lock    <= 8'd0;
      cfg.platters      <= 3'd1;
      cfg.memory_fields <= 4'd8;
      cfg.burst         <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        fhd_pkg::CFG_WRITE_LOCK:    cfg.write_lock    <= cfg_data;
        fhd_pkg::CFG_PLATTERS:      cfg.platters      <= cfg_data[2:0];
        fhd_pkg::CFG_MEMORY_FIELDS: cfg.memory_fields <= cfg_data[3:0];
        fhd_pkg::CFG_BURST:         cfg.burst         <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fhd_core.sv =====
`default_nettype none
module fhd_core #(
  parameter int WORDS_PER_TRACK = 2048,
  parameter int PLATTER_WORDS   = 32768
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fhd_pkg::in_item_t item,
  input  wire logic              fire,
  input  wire fhd_pkg::cfg_t     cfg,
  output fhd_pkg::res_t          res
);

  // restoring division by the track length, one compare/subtract per quotient bit
  localparam int QSTEPS = $clog2(4095 / WORDS_PER_TRACK + 1);

  function automatic logic [11:0] track_mod(input logic [11:0] x);
    logic [24:0] r;
    logic [24:0] dv;
    r = 25'(x);
    for (int k = QSTEPS - 1; k >= 0; k--) begin
      dv = 25'(WORDS_PER_TRACK) << k;
      if (r >= dv) begin
        r = r - dv;
      end
    end
    return r[11:0];
  endfunction

  logic [11:0] status_reg, status_next;
  logic [11:0] disk_addr_low, disk_addr_low_next;
  logic [2:0]  function_code, function_code_next;
  logic        done_flag, done_next;
  logic        irq_flag, irq_next;

  logic [11:0] cp;
  logic [11:0] tgt;
  logic [11:0] st_pc;
  logic [12:0] dly;
  logic [16:0] da;
  logic [17:0] cap;
  logic [14:0] pa;
  logic [15:0] mem_top;
  logic        refused;
  logic        cont;

  assign cp  = track_mod({1'b0, item.position});
  // target word of a start: the address after an optional clear, merged with ac
  assign tgt = track_mod((item.pulse[0] ? 12'd0 : disk_addr_low) | item.ac);
  assign cap = 18'(cfg.platters) * 18'(PLATTER_WORDS);
  assign mem_top = {cfg.memory_fields, 12'd0};
  assign st_pc = (cp < fhd_pkg::PCELL_WINDOW) ? (status_reg | fhd_pkg::ST_PCELL)
                                              : (status_reg & ~fhd_pkg::ST_PCELL);

  always_comb begin
    status_next        = status_reg;
    disk_addr_low_next = disk_addr_low;
    function_code_next = function_code;
    done_next          = done_flag;
    irq_next           = irq_flag;
    res                = '0;
    dly                = 13'd0;
    da                 = {status_reg[10:6], disk_addr_low};
    pa                 = 15'd0;
    refused            = 1'b0;
    cont               = 1'b0;
    case (item.opcode)
      fhd_pkg::OP_IOT60: begin
        status_next = st_pc;
        res.ac_out  = item.ac;
        if (item.pulse[0]) begin
          disk_addr_low_next = 12'd0;
          done_next          = 1'b0;
          irq_next           = 1'b0;
          status_next        = status_next & ~fhd_pkg::ST_ERR;
        end
        if (item.pulse[2:1] != 2'd0) begin
          disk_addr_low_next = disk_addr_low_next | item.ac;
          function_code_next = {item.pulse[2:1], 1'b0};
          if (tgt >= cp) begin
            dly = 13'(tgt) - 13'(cp);
          end else begin
            dly = 13'(tgt) + 13'(WORDS_PER_TRACK) - 13'(cp);
          end
          res.delay_words = dly[10:0];
          res.next_event  = fhd_pkg::EV_START;
          res.ac_out      = 12'd0;
        end
      end
      fhd_pkg::OP_IOT61: begin
        status_next = st_pc;
        res.ac_out  = item.ac;
        if (item.pulse[0]) begin
          status_next = status_next & ~(fhd_pkg::ST_DEX | fhd_pkg::ST_MEX);
        end
        if (item.pulse[1]) begin
          res.skip   = (track_mod(disk_addr_low) == cp);
          res.ac_out = 12'd0;
        end
        if (item.pulse[2]) begin
          // extension load, then read back the status from before this transaction
          status_next = status_next | (res.ac_out & (fhd_pkg::ST_DEX | fhd_pkg::ST_MEX));
          res.ac_out  = res.ac_out | status_reg;
        end
      end
      fhd_pkg::OP_IOT62: begin
        status_next = st_pc;
        res.ac_out  = item.ac;
        if (item.pulse[0] && (st_pc & fhd_pkg::ST_ERR) == 12'd0) begin
          res.skip = 1'b1;
        end
        if (item.pulse[1]) begin
          if (item.pulse[2]) begin
            res.ac_out = 12'd0;
          end else if (done_flag) begin
            res.skip = 1'b1;
          end
        end
        if (item.pulse[2]) begin
          res.ac_out = res.ac_out | disk_addr_low;
        end
      end
      fhd_pkg::OP_XFER: begin
        status_next           = st_pc;
        res.count_out         = item.word_count;
        res.address_out       = item.memory_address;
        res.disk_word_address = da;
        if ({1'b0, da} >= cap) begin
          status_next = status_next | fhd_pkg::ST_NXD;
          refused     = 1'b1;
        end else begin
          res.count_out   = item.word_count + 12'd1;
          res.address_out = item.memory_address + 12'd1;
          pa = {status_reg[5:3], res.address_out};
          res.physical_address = pa;
          if (function_code == fhd_pkg::FN_READ) begin
            if ({1'b0, pa} < mem_top) begin
              res.move = fhd_pkg::MV_READ;
            end
          end else if (cfg.write_lock[da[16:14]]) begin
            status_next = status_next | fhd_pkg::ST_WLS;
          end else begin
            res.move = fhd_pkg::MV_WRITE;
          end
          da = da + 17'd1;
        end
        cont = !refused && res.count_out != 12'd0 &&
               (cfg.burst || (status_next & fhd_pkg::ST_ERR) == 12'd0);
        if (cont) begin
          res.next_event = fhd_pkg::EV_NEXT;
        end else begin
          if (function_code != fhd_pkg::FN_READ) begin
            da = da - 17'd1;
          end
          done_next = 1'b1;
          irq_next  = 1'b1;
        end
        status_next        = (status_next & ~fhd_pkg::ST_DEX) | {1'b0, da[16:12], 6'd0};
        disk_addr_low_next = da[11:0];
      end
      fhd_pkg::OP_RESET: begin
        status_next        = 12'd0;
        disk_addr_low_next = 12'd0;
        done_next          = 1'b1;
        irq_next           = 1'b0;
      end
      default: ;
    endcase
    res.done_out   = done_next;
    res.interrupt  = irq_next;
    res.status_out = status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg    <= 12'd0;
      disk_addr_low <= 12'd0;
      function_code <= 3'd0;
      done_flag     <= 1'b1;
      irq_flag      <= 1'b0;
    end else if (fire) begin
      status_reg    <= status_next;
      disk_addr_low <= disk_addr_low_next;
      function_code <= function_code_next;
      done_flag     <= done_next;
      irq_flag      <= irq_next;
    end
  end

endmodule
`default_nettype wire

// ===== dv/fhd_checker.sv =====
module fhd_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [fhd_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [2:0]                     s_tuser,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [fhd_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [fhd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  results_seen
);

  localparam int PLATTER_SPAN = 32768;
  localparam int FIELD_SPAN   = 4096;
  localparam int MAX_LINES    = 30;

  // controller state as the software sees it
  logic [11:0] dsk_status;
  logic [11:0] dsk_addr_lo;
  logic [2:0]  dsk_func;
  logic        dsk_done;
  logic        dsk_irq;

  logic [7:0]  lock_map;
  logic [2:0]  n_platters;
  logic [3:0]  n_fields;
  logic        burst_mode;

  fhd_pkg::res_t awaited_results[$];

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    // keep the log short when something is badly broken
    if (mismatches <= MAX_LINES)
      $display("ERROR result %0d %s: got 'o%0o expected 'o%0o", results_seen, what, got, want);
  endtask

  // pulse bit meanings differ per group; bit 0/1/2 are the three pulse lines.
  // track position is taken modulo 2048 words, i.e. the low 11 bits
  function automatic fhd_pkg::res_t step_controller(input logic [2:0] op,
                                                    input logic [2:0] pulse,
                                                    input logic [11:0] ac,
                                                    input logic [10:0] pos,
                                                    input logic [11:0] wc,
                                                    input logic [11:0] ma);
    fhd_pkg::res_t r;
    logic [11:0]   prior;
    logic [14:0]   mem_ext;
    logic [16:0]   daddr;
    logic          refused;
    r       = '0;
    refused = 1'b0;
    prior   = dsk_status;
    mem_ext = {dsk_status[5:3], 12'd0};
    daddr   = {dsk_status[10:6], dsk_addr_lo};
    if (op <= fhd_pkg::OP_XFER) begin
      if ({1'b0, pos} < fhd_pkg::PCELL_WINDOW) dsk_status = dsk_status | fhd_pkg::ST_PCELL;
      else dsk_status = dsk_status & ~fhd_pkg::ST_PCELL;
    end
    case (op)
      fhd_pkg::OP_IOT60: begin
        r.ac_out = ac;
        if (pulse[0]) begin
          dsk_addr_lo = '0;
          dsk_done    = 1'b0;
          dsk_irq     = 1'b0;
          dsk_status  = dsk_status & ~fhd_pkg::ST_ERR;
        end
        if (pulse[2:1] != 2'b00) begin
          dsk_addr_lo   = dsk_addr_lo | ac;
          dsk_func      = {pulse[2:1], 1'b0};
          // rotational distance wraps around the track
          r.delay_words = dsk_addr_lo[10:0] - pos;
          r.next_event  = fhd_pkg::EV_START;
          r.ac_out      = '0;
        end
      end
      fhd_pkg::OP_IOT61: begin
        r.ac_out = ac;
        if (pulse[0]) dsk_status = dsk_status & ~(fhd_pkg::ST_DEX | fhd_pkg::ST_MEX);
        if (pulse[1]) begin
          r.skip   = (dsk_addr_lo[10:0] == pos);
          r.ac_out = '0;
        end
        if (pulse[2]) begin
          dsk_status = dsk_status | (r.ac_out & (fhd_pkg::ST_DEX | fhd_pkg::ST_MEX));
          r.ac_out   = r.ac_out | prior;
        end
      end
      fhd_pkg::OP_IOT62: begin
        r.ac_out = ac;
        if (pulse[0] && (dsk_status & fhd_pkg::ST_ERR) == '0) r.skip = 1'b1;
        if (pulse[1]) begin
          if (pulse[2]) r.ac_out = '0;
          else if (dsk_done) r.skip = 1'b1;
        end
        if (pulse[2]) r.ac_out = r.ac_out | dsk_addr_lo;
      end
      fhd_pkg::OP_XFER: begin
        r.count_out         = wc;
        r.address_out       = ma;
        r.disk_word_address = daddr;
        if (int'(daddr) >= int'(n_platters) * PLATTER_SPAN) begin
          dsk_status = dsk_status | fhd_pkg::ST_NXD;
          refused    = 1'b1;
        end else begin
          r.count_out        = wc + 12'd1;
          r.address_out      = ma + 12'd1;
          r.physical_address = mem_ext | {3'd0, r.address_out};
          if (dsk_func == fhd_pkg::FN_READ) begin
            if (int'(r.physical_address) < int'(n_fields) * FIELD_SPAN)
              r.move = fhd_pkg::MV_READ;
          end else if (lock_map[daddr[16:14]]) begin
            dsk_status = dsk_status | fhd_pkg::ST_WLS;
          end else begin
            r.move = fhd_pkg::MV_WRITE;
          end
          daddr = daddr + 17'd1;
        end
        if (!refused && r.count_out != '0 &&
            (burst_mode || (dsk_status & fhd_pkg::ST_ERR) == '0)) begin
          r.next_event = fhd_pkg::EV_NEXT;
        end else begin
          // a finished write leaves the address on the last word written
          if (dsk_func != fhd_pkg::FN_READ) daddr = daddr - 17'd1;
          dsk_done = 1'b1;
          dsk_irq  = 1'b1;
        end
        dsk_status[10:6] = daddr[16:12];
        dsk_addr_lo      = daddr[11:0];
      end
      fhd_pkg::OP_RESET: begin
        dsk_status  = '0;
        dsk_addr_lo = '0;
        dsk_done    = 1'b1;
        dsk_irq     = 1'b0;
      end
      default: ;
    endcase
    r.done_out   = dsk_done;
    r.interrupt  = dsk_irq;
    r.status_out = dsk_status;
    return r;
  endfunction

  always @(posedge clk) begin
    fhd_pkg::res_t seen;
    fhd_pkg::res_t want;
    if (rst) begin
      dsk_status   = '0;
      dsk_addr_lo  = '0;
      dsk_func     = '0;
      dsk_done     = 1'b1;
      dsk_irq      = 1'b0;
      lock_map     = 8'd0;
      n_platters   = 3'd1;
      n_fields     = 4'd8;
      burst_mode   = 1'b1;
      mismatches   = 0;
      results_seen = 0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen = m_tdata[$bits(fhd_pkg::res_t)-1:0];
        results_seen++;
        if (awaited_results.size() == 0) begin
          report("result with no transaction pending", int'(seen.status_out), 0);
        end else begin
          want = awaited_results.pop_front();
          if (seen.ac_out != want.ac_out) report("ac_out", seen.ac_out, want.ac_out);
          if (seen.skip != want.skip) report("skip", seen.skip, want.skip);
          if (seen.next_event != want.next_event)
            report("next_event", seen.next_event, want.next_event);
          if (seen.delay_words != want.delay_words)
            report("delay_words", seen.delay_words, want.delay_words);
          if (seen.count_out != want.count_out)
            report("count_out", seen.count_out, want.count_out);
          if (seen.address_out != want.address_out)
            report("address_out", seen.address_out, want.address_out);
          if (seen.physical_address != want.physical_address)
            report("physical_address", seen.physical_address, want.physical_address);
          if (seen.disk_word_address != want.disk_word_address)
            report("disk_word_address", seen.disk_word_address, want.disk_word_address);
          if (seen.move != want.move) report("move", seen.move, want.move);
          if (seen.done_out != want.done_out) report("done_out", seen.done_out, want.done_out);
          if (seen.interrupt != want.interrupt)
            report("interrupt", seen.interrupt, want.interrupt);
          if (seen.status_out != want.status_out)
            report("status_out", seen.status_out, want.status_out);
          if (m_tdata[fhd_pkg::OUT_DATA_W-1:$bits(fhd_pkg::res_t)] != '0)
            report("tdata padding",
                   int'(m_tdata[fhd_pkg::OUT_DATA_W-1:$bits(fhd_pkg::res_t)]), 0);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          fhd_pkg::CFG_WRITE_LOCK:    lock_map   = cfg_data;
          fhd_pkg::CFG_PLATTERS:      n_platters = cfg_data[2:0];
          fhd_pkg::CFG_MEMORY_FIELDS: n_fields   = cfg_data[3:0];
          fhd_pkg::CFG_BURST:         burst_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(step_controller(s_tuser, s_tdata[2:0], s_tdata[14:3],
                                                  s_tdata[25:15], s_tdata[37:26],
                                                  s_tdata[49:38]));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;

  localparam int IDLE_PCT     = 23;
  localparam int LIMIT_CYCLES = 200000;

  // pulse lines per device group
  localparam logic [2:0] P60_CLEAR     = 3'b001;
  localparam logic [2:0] P60_READ      = 3'b010;
  localparam logic [2:0] P60_WRITE     = 3'b100;
  localparam logic [2:0] P61_CLEAR_EXT = 3'b001;
  localparam logic [2:0] P61_SKIP_ADDR = 3'b010;
  localparam logic [2:0] P61_EXT       = 3'b100;
  localparam logic [2:0] P62_SKIP_OK   = 3'b001;
  localparam logic [2:0] P62_SKIP_DONE = 3'b010;
  localparam logic [2:0] P62_ADDR      = 3'b100;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [fhd_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic [2:0]                     s_tuser   = '0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [fhd_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we    = 1'b0;
  logic [1:0]                     cfg_index = '0;
  logic [fhd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int   mismatches;
  int   outstanding;
  int   results_seen;
  int   items_taken    = 0;
  int   items_sent     = 0;
  int   settings_used  = 0;
  int   cycle_count    = 0;
  int   cur_plat       = 1;
  logic steady         = 1'b0;

  fixed_head_disk_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fhd_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) items_taken <= items_taken + 1;
  end

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("fixed_head_disk_controller: mismatch");
      $finish;
    end
  end

  function automatic logic [11:0] any_word();
    return 12'($urandom);
  endfunction

  function automatic logic [2:0] any_pulse();
    return 3'($urandom);
  endfunction

  // bias toward the photocell window at the start of the track
  function automatic logic [10:0] any_pos();
    if ($urandom_range(4) == 0) return 11'($urandom_range(7));
    return 11'($urandom);
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [2:0] pulse, input logic [11:0] ac,
                           input logic [10:0] pos, input logic [11:0] wc, input logic [11:0] ma);
    int goal;
    goal = items_taken + 1;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, ma, wc, pos, ac, pulse};
    do @(negedge clk); while (items_taken < goal);
    items_sent++;
  endtask

  // registers change only with nothing in flight
  task automatic load_settings(input logic [7:0] lock, input logic [2:0] plat,
                               input logic [3:0] fields, input logic brst);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= fhd_pkg::CFG_WRITE_LOCK;
    cfg_data  <= lock;
    @(negedge clk);
    cfg_index <= fhd_pkg::CFG_PLATTERS;
    cfg_data  <= {5'd0, plat};
    @(negedge clk);
    cfg_index <= fhd_pkg::CFG_MEMORY_FIELDS;
    cfg_data  <= {4'd0, fields};
    @(negedge clk);
    cfg_index <= fhd_pkg::CFG_BURST;
    cfg_data  <= {7'd0, brst};
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_plat = int'(plat);
    settings_used++;
  endtask

  task automatic noise_item();
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(99);
    // mostly the three groups and transfers, now and then a controller reset
    if (pick < 4) op = fhd_pkg::OP_RESET;
    else op = 3'(pick % 4);
    send_item(op, any_pulse(), any_word(), any_pos(), any_word(), any_word());
  endtask

  task automatic random_traffic(input int quota);
    int          stop_at;
    int          words;
    int          pick;
    int          k;
    logic [11:0] word;
    logic [11:0] addr;
    logic [11:0] count0;
    logic [11:0] mem0;
    logic [4:0]  ext;
    logic [2:0]  fn;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 20) begin
        noise_item();
      end else begin
        // extension load, clear and start, then a run of data-break words
        word = any_word();
        if (cur_plat >= 1 && cur_plat <= 4 && $urandom_range(9) != 0)
          ext = 5'($urandom_range(cur_plat * 8 - 1));
        else
          ext = 5'($urandom);
        word[10:6] = ext;
        send_item(fhd_pkg::OP_IOT61,
                  ($urandom_range(3) == 0) ? P61_EXT : (P61_EXT | P61_CLEAR_EXT),
                  word, any_pos(), any_word(), any_word());
        pick = $urandom_range(99);
        fn   = (pick < 50) ? P60_READ : (pick < 85) ? P60_WRITE : (P60_READ | P60_WRITE);
        addr = any_word();
        if ($urandom_range(6) == 0) addr = 12'o7777 - 12'($urandom_range(3));
        if ($urandom_range(3) != 0) begin
          send_item(fhd_pkg::OP_IOT60, P60_CLEAR | fn, addr, any_pos(), any_word(), any_word());
        end else begin
          send_item(fhd_pkg::OP_IOT60, P60_CLEAR, any_word(), any_pos(), any_word(),
                    any_word());
          send_item(fhd_pkg::OP_IOT60, fn, addr, any_pos(), any_word(), any_word());
        end
        if ($urandom_range(4) == 0)
          send_item(fhd_pkg::OP_IOT61, P61_SKIP_ADDR, any_word(), addr[10:0], any_word(),
                    any_word());
        words = $urandom_range(1, 8);
        if ($urandom_range(3) != 0) count0 = 12'(4096 - words);
        else count0 = any_word();
        if ($urandom_range(7) == 0) mem0 = 12'o7775;
        else mem0 = any_word();
        for (k = 0; k < words; k++) begin
          if ($urandom_range(9) == 0)
            send_item(fhd_pkg::OP_IOT62, any_pulse(), any_word(), any_pos(), any_word(),
                      any_word());
          send_item(fhd_pkg::OP_XFER, any_pulse(), any_word(), any_pos(), count0 + 12'(k),
                    mem0 + 12'(k));
        end
        if ($urandom_range(1) == 0)
          send_item(fhd_pkg::OP_IOT62, any_pulse(), any_word(), any_pos(), any_word(),
                    any_word());
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: skips after reset, extension load and read-back, refused disk
    // address, read and write runs that end, combined pulses, reset command
    send_item(fhd_pkg::OP_IOT62, P62_SKIP_DONE, 12'o1234, 11'd0, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT62, P62_SKIP_OK, 12'o7777, 11'd5, 12'o7777, 12'o7777);
    send_item(fhd_pkg::OP_IOT61, P61_EXT, 12'o7777, 11'd2047, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT61, P61_EXT, 12'd0, 11'd6, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT62, P62_ADDR, 12'o7777, 11'd1, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT62, P62_SKIP_DONE | P62_ADDR, 12'o5252, 11'd3, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT60, P60_CLEAR, 12'd0, 11'd10, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT62, P62_SKIP_DONE, 12'd0, 11'd10, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT60, P60_READ, 12'o7777, 11'd5, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_XFER, 3'd0, 12'd0, 11'd9, 12'o7777, 12'o7777);
    send_item(fhd_pkg::OP_IOT62, P62_SKIP_OK, 12'd0, 11'd9, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT61, P61_CLEAR_EXT, 12'd0, 11'd9, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT60, P60_CLEAR | P60_READ, 12'd0, 11'd0, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_XFER, 3'd7, 12'o7777, 11'd3, 12'o7776, 12'o7777);
    send_item(fhd_pkg::OP_XFER, 3'd0, 12'd0, 11'd4, 12'o7777, 12'd0);
    send_item(fhd_pkg::OP_IOT61, P61_SKIP_ADDR, 12'o7777, 11'd2, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT60, P60_CLEAR | P60_WRITE, 12'o4000, 11'd100, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_XFER, 3'd0, 12'd0, 11'd2047, 12'o7777, 12'o0005);
    send_item(fhd_pkg::OP_IOT60, P60_CLEAR | P60_READ | P60_WRITE, 12'd1, 11'd1, 12'd0,
              12'd0);
    send_item(fhd_pkg::OP_XFER, 3'd0, 12'd0, 11'd7, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT61, P61_CLEAR_EXT | P61_SKIP_ADDR | P61_EXT, 12'o7777, 11'd1,
              12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT62, P62_SKIP_OK | P62_SKIP_DONE | P62_ADDR, 12'o1234, 11'd8,
              12'd0, 12'd0);
    send_item(fhd_pkg::OP_RESET, 3'd7, 12'o7777, 11'd2047, 12'o7777, 12'o7777);
    send_item(fhd_pkg::OP_IOT60, 3'd0, 12'o7777, 11'd1024, 12'd0, 12'd0);
    send_item(fhd_pkg::OP_IOT62, P62_SKIP_OK | P62_SKIP_DONE, 12'd0, 11'd0, 12'd0, 12'd0);

    // full-rate stretch on both sides
    load_settings(8'h00, 3'd4, 4'd8, 1'b1);
    steady = 1'b1;
    random_traffic(200);
    steady = 1'b0;
    load_settings(8'hff, 3'd1, 4'd1, 1'b0);
    random_traffic(170);
    load_settings(8'($urandom), 3'd2, 4'd5, 1'b0);
    random_traffic(170);
    load_settings(8'($urandom), 3'd3, 4'($urandom_range(1, 8)), 1'b1);
    random_traffic(170);
    load_settings(8'($urandom), 3'd4, 4'd8, 1'b0);
    random_traffic(170);
    // no disk and no memory at all, then oversized values
    load_settings(8'($urandom), 3'd0, 4'd0, 1'($urandom));
    random_traffic(60);
    load_settings(8'($urandom), 3'd7, 4'd15, 1'($urandom));
    random_traffic(120);

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("sent %0d command and transfer transactions under %0d register settings",
             items_sent, settings_used + 1);
    $display("compared %0d results field by field, %0d field errors", results_seen, mismatches);
    if (mismatches == 0) $display("fixed_head_disk_controller: match");
    else $display("fixed_head_disk_controller: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fhd_pkg.sv
hdl/fhd_stage.sv
hdl/fhd_cfg.sv
hdl/fhd_core.sv
hdl/fixed_head_disk_controller.sv
dv/fhd_checker.sv
dv/testbench.sv
